// ===== hw/rtl/lfrg_pkg.sv =====
// Package with the shared constants, types and the gamma table of the LED fade unit.
`timescale 1ns / 1ps
`default_nettype none
package lfrg_pkg;

   localparam int QueueDepth = 256;
   localparam int IndexWidth = $clog2(QueueDepth);
   localparam int GammaScale = 1023;
   localparam int GammaRound = 32512;
   localparam int GammaDiv   = 65025;

   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [9:0] gamma_table_type [256];

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_RAMP,
      S_TARGET,
      S_EXTRA,
      S_READ,
      S_OUT
   } state_type;

   function automatic gamma_table_type build_gamma();
      gamma_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 10'((GammaScale * i * i + GammaRound) / GammaDiv);
      end
      return t;
   endfunction

   localparam gamma_table_type GammaTable = build_gamma();

   function automatic index_type next_slot(input index_type i);
      return (i == index_type'(QueueDepth - 1)) ? '0 : index_type'(i + 1'b1);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lfrg_div.sv =====
// Restoring divider that splits the fade difference by the fade length, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lfrg_div
   import lfrg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [7:0] dividend,
   input  wire logic [7:0] divisor,
   output logic            done,
   output logic [7:0]      quotient,
   output logic [7:0]      remainder
);

   logic [7:0] quo_ff, quo_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] dvs_ff, dvs_in;
   logic [3:0] count_ff, count_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [8:0] shifted;

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, quo_ff[7]};
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = 8'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = shifted[7:0];
            quo_in = {quo_ff[6:0], 1'b0};
         end
         count_in = 4'(count_ff + 1'b1);
         if (count_ff == 4'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/led_fade_ramp_gamma_unit.sv =====
// Top level of the LED fade unit: level queue in a memory, ramp sequencer and gamma output.
`timescale 1ns / 1ps
`default_nettype none
// One beat on req_ is one dimmer tick and yields exactly one beat on rsp_. When the
// channel-one target changes with a fade length of two or more, the sequencer starts the
// divider in the cycle after the beat is accepted and takes the quotient and remainder
// when the divider's registered done goes high. After that the sequencer writes one ramp
// level per cycle into the level queue memory, then the target. A change without a fade
// skips the divider and the ramp; an unchanged target also skips the target write.
// The queue memory has one write port and one registered read port; the dequeue read
// is issued only after all writes of the tick. A finished result waits in the output
// register while the next tick is accepted. A tick whose result is ready while the
// previous result still waits stalls until rsp_tready takes that earlier beat.
module led_fade_ramp_gamma_unit
   import lfrg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: target_one[7:0], fade_ticks[15:8], target_two[23:16].
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: duty_one[9:0], duty_two[19:10], zero fill[23:20].
   output logic [23:0]      rsp_tdata
);

   state_type  state_ff, state_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] two_ff, two_in;
   logic [7:0] from_ff, from_in;
   logic [7:0] diff_ff, diff_in;
   logic       up_ff, up_in;
   logic [7:0] q_ff, q_in;
   logic [7:0] r_ff, r_in;
   logic [7:0] qd_ff, qd_in;
   logic [7:0] rd_ff, rd_in;
   logic [7:0] i_ff, i_in;
   index_type  head_ff, head_in;
   index_type  tail_ff, tail_in;
   logic       empty_ff, empty_in;
   logic       zero_ff, zero_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [9:0] duty_one_ff, duty_one_in;
   logic [9:0] duty_two_ff, duty_two_in;
   logic       div_kick_ff;

   logic [7:0] mem [QueueDepth];
   logic [7:0] rd_data_ff;
   logic       rd_en;

   logic       push_do;
   logic [7:0] push_value;
   logic       wr_en;
   index_type  wr_addr;
   logic       full;
   logic       room;
   logic [8:0] r_sum;
   logic [7:0] ramp_value;
   logic       accept;
   logic       out_load;

   logic       div_start;
   logic       div_done;
   logic [7:0] div_quo;
   logic [7:0] div_rem;

   lfrg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (diff_ff),
      .divisor   (len_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign full = !empty_ff && (next_slot(tail_ff) == head_ff);
   assign room = empty_ff || !((tail_ff > head_ff) && (index_type'(tail_ff - head_ff) > 1));
   assign r_sum = {1'b0, r_ff} + {1'b0, rd_ff};
   assign ramp_value = up_ff ? 8'(from_ff + q_ff) : 8'(from_ff - q_ff);
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      target_in    = target_ff;
      len_in       = len_ff;
      two_in       = two_ff;
      from_in      = from_ff;
      diff_in      = diff_ff;
      up_in        = up_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      qd_in        = qd_ff;
      rd_in        = rd_ff;
      i_in         = i_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      duty_one_in  = duty_one_ff;
      duty_two_in  = duty_two_ff;
      push_do      = 1'b0;
      push_value   = target_ff;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               target_in = req_tdata[7:0];
               len_in    = req_tdata[15:8];
               two_in    = req_tdata[23:16];
               from_in   = prev_ff;
               prev_in   = req_tdata[7:0];
               up_in     = req_tdata[7:0] > prev_ff;
               diff_in   = (req_tdata[7:0] > prev_ff) ? 8'(req_tdata[7:0] - prev_ff)
                                                      : 8'(prev_ff - req_tdata[7:0]);
               if (req_tdata[7:0] == prev_ff) begin
                  state_in = S_EXTRA;
               end else if (req_tdata[15:8] > 8'd1) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_TARGET;
               end
            end
         end
         S_DIV: begin
            div_start = div_kick_ff;
            if (div_done) begin
               qd_in    = div_quo;
               rd_in    = div_rem;
               q_in     = div_quo;
               r_in     = div_rem;
               i_in     = 8'd1;
               state_in = S_RAMP;
            end
         end
         S_RAMP: begin
            push_do    = 1'b1;
            push_value = ramp_value;
            if (r_sum >= {1'b0, len_ff}) begin
               r_in = 8'(r_sum - {1'b0, len_ff});
               q_in = 8'(q_ff + qd_ff + 1'b1);
            end else begin
               r_in = r_sum[7:0];
               q_in = 8'(q_ff + qd_ff);
            end
            i_in = 8'(i_ff + 1'b1);
            if (i_ff == 8'(len_ff - 1'b1)) begin
               state_in = S_TARGET;
            end
         end
         S_TARGET: begin
            push_do  = 1'b1;
            state_in = S_EXTRA;
         end
         S_EXTRA: begin
            push_do  = room;
            state_in = S_READ;
         end
         S_READ: begin
            zero_in = empty_ff;
            if (!empty_ff) begin
               rd_en = 1'b1;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  head_in = next_slot(head_ff);
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               duty_one_in  = zero_ff ? GammaTable[0] : GammaTable[rd_data_ff];
               duty_two_in  = GammaTable[two_ff];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      wr_en   = 1'b0;
      wr_addr = tail_ff;
      if (push_do && !full) begin
         wr_en = 1'b1;
         if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_addr  = '0;
         end else begin
            tail_in = next_slot(tail_ff);
            wr_addr = next_slot(tail_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_kick_ff <= 1'b0;
      end else begin
         div_kick_ff <= accept && (req_tdata[7:0] != prev_ff) && (req_tdata[15:8] > 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff   <= target_in;
      len_ff      <= len_in;
      two_ff      <= two_in;
      from_ff     <= from_in;
      diff_ff     <= diff_in;
      up_ff       <= up_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      qd_ff       <= qd_in;
      rd_ff       <= rd_in;
      i_ff        <= i_in;
      zero_ff     <= zero_in;
      duty_one_ff <= duty_one_in;
      duty_two_ff <= duty_two_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, duty_two_ff, duty_one_ff};

endmodule
`default_nettype wire

// ===== bench/led_fade_ramp_gamma_unit_tb.sv =====
// Self-checking bench for the LED fade unit that checks each tick against a fade queue predictor.
`timescale 1ns / 1ps
module led_fade_ramp_gamma_unit_tb;
   import lfrg_pkg::*;

   localparam int CycleLimit  = 1_500_000;
   localparam int DrainCycles = 300;

   typedef struct packed {
      logic [9:0] duty_one;
      logic [9:0] duty_two;
   } duty_pair_type;

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY
   } stall_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Fields from bit 0: target_one[7:0], fade_ticks[15:8], target_two[23:16].
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Fields from bit 0: duty_one[9:0], duty_two[19:10], zero fill[23:20].
   logic [23:0] rsp_tdata;

   logic [23:0]   tick_pending_q[$];
   duty_pair_type duty_expect_q[$];
   int            error_count = 0;
   int            cycle_count = 0;

   logic [7:0]  last_target = '0;
   logic [7:0]  level_mem [QueueDepth];
   int unsigned head_ptr = 0;
   int unsigned tail_ptr = 0;
   bit          level_fifo_empty = 1'b1;

   int             burst_left = 0;
   int             gap_left = 0;
   stall_mode_type stall_mode = READY_ALWAYS;
   int             mode_left = 0;

   led_fade_ramp_gamma_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned slot_after(int unsigned i);
      return (i + 1 >= QueueDepth) ? 0 : i + 1;
   endfunction

   function automatic void level_push(logic [7:0] v);
      if (!level_fifo_empty && slot_after(tail_ptr) == head_ptr) begin
         return;
      end
      if (level_fifo_empty) begin
         head_ptr = 0;
         tail_ptr = 0;
         level_fifo_empty = 1'b0;
      end else begin
         tail_ptr = slot_after(tail_ptr);
      end
      level_mem[tail_ptr] = v;
   endfunction

   function automatic logic [7:0] level_pop();
      logic [7:0] v;
      if (level_fifo_empty) begin
         return 8'd0;
      end
      v = level_mem[head_ptr];
      if (head_ptr == tail_ptr) begin
         level_fifo_empty = 1'b1;
         head_ptr = 0;
         tail_ptr = 0;
      end else begin
         head_ptr = slot_after(head_ptr);
      end
      return v;
   endfunction

   function automatic logic [9:0] gamma_duty(logic [7:0] v);
      int unsigned sq;
      sq = GammaScale * v * v + GammaRound;
      return 10'(sq / GammaDiv);
   endfunction

   function automatic duty_pair_type fade_tick_predict(logic [23:0] beat);
      logic [7:0]    goal;
      logic [7:0]    span;
      logic [7:0]    level;
      int unsigned   diff;
      int unsigned   offset;
      duty_pair_type res;
      goal = beat[7:0];
      span = beat[15:8];
      if (goal != last_target) begin
         diff = (goal > last_target) ? goal - last_target : last_target - goal;
         for (int unsigned i = 1; i < span; i++) begin
            offset = (i * diff) / span;
            if (goal > last_target) begin
               level_push(8'(last_target + offset));
            end else begin
               level_push(8'(last_target - offset));
            end
         end
         level_push(goal);
      end
      last_target = goal;
      if (level_fifo_empty || !(tail_ptr > head_ptr && tail_ptr - head_ptr > 1)) begin
         level_push(goal);
      end
      level = level_pop();
      res.duty_one = gamma_duty(level);
      res.duty_two = gamma_duty(beat[23:16]);
      return res;
   endfunction

   function automatic void add_tick(logic [7:0] t1, logic [7:0] fade, logic [7:0] t2);
      tick_pending_q.push_back({t2, fade, t1});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (tick_pending_q.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= tick_pending_q.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 15);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_MOSTLY: begin
               rsp_tready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin : beat_check
      duty_pair_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            duty_expect_q.push_back(fade_tick_predict(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (duty_expect_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual duty_one=%0d duty_two=%0d",
                        $time, rsp_tdata[9:0], rsp_tdata[19:10]);
               error_count++;
            end else begin
               want = duty_expect_q.pop_front();
               if (rsp_tdata[9:0] !== want.duty_one) begin
                  $display("%0t: duty_one mismatch, expected %0d, actual %0d",
                           $time, want.duty_one, rsp_tdata[9:0]);
                  error_count++;
               end
               if (rsp_tdata[19:10] !== want.duty_two) begin
                  $display("%0t: duty_two mismatch, expected %0d, actual %0d",
                           $time, want.duty_two, rsp_tdata[19:10]);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [7:0] goal;
      logic [7:0] fade;
      int         hold;
      int         noise;
      int         n;

      add_tick(8'd0,   8'd0,   8'd0);
      add_tick(8'd255, 8'd255, 8'd255);
      add_tick(8'd0,   8'd255, 8'd0);
      add_tick(8'd0,   8'd170, 8'd85);
      add_tick(8'd1,   8'd1,   8'd1);
      add_tick(8'd200, 8'd0,   8'd170);
      add_tick(8'd100, 8'd2,   8'd200);
      add_tick(8'd101, 8'd3,   8'd50);
      add_tick(8'd0,   8'd85,  8'd254);
      add_tick(8'd128, 8'd128, 8'd127);
      add_tick(8'd128, 8'd0,   8'd128);
      add_tick(8'd127, 8'd4,   8'd64);
      add_tick(8'd255, 8'd1,   8'd32);
      add_tick(8'd254, 8'd254, 8'd16);
      add_tick(8'd0,   8'd7,   8'd8);

      // Mostly fades followed by holds that drain the queue, with some fully random ticks.
      n = 0;
      while (n < 1100) begin
         if ($urandom_range(0, 9) < 7) begin
            goal = 8'($urandom);
            fade = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(13, 255))
                                                : 8'($urandom_range(0, 12));
            add_tick(goal, fade, 8'($urandom));
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 300)
                                                : $urandom_range(0, 12);
            repeat (hold) add_tick(goal, 8'($urandom), 8'($urandom));
            n += hold + 1;
         end else begin
            noise = $urandom_range(1, 6);
            repeat (noise) add_tick(8'($urandom), 8'($urandom), 8'($urandom));
            n += noise;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (tick_pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (duty_expect_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== led_fade_ramp_gamma_unit.f =====
hw/rtl/lfrg_pkg.sv
hw/rtl/lfrg_div.sv
hw/rtl/led_fade_ramp_gamma_unit.sv
bench/led_fade_ramp_gamma_unit_tb.sv
